// ===== rtl/cla_pkg.sv =====
// shared constants and types for the command line assembler
`timescale 1ns / 1ps

package cla_pkg;

    localparam int LINE_CAPACITY = 64;
    localparam int STORE_DEPTH   = 64;
    localparam int ADDR_W        = 6;
    localparam int COUNT_W       = 6;

    localparam logic [7:0] BYTE_CR  = 8'h0D;
    localparam logic [7:0] BYTE_LF  = 8'h0A;
    localparam logic [7:0] BYTE_BS  = 8'h08;
    localparam logic [7:0] BYTE_DEL = 8'h7F;
    localparam logic [7:0] PRINT_LO = 8'd32;
    localparam logic [7:0] PRINT_HI = 8'd126;

    // most characters a line may hold
    localparam logic [COUNT_W-1:0] FULL_COUNT = COUNT_W'(LINE_CAPACITY - 1);

    localparam logic KIND_CHAR  = 1'b0;
    localparam logic KIND_ERROR = 1'b1;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        data;
    } t_wr_req;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
    } t_rd_req;

endpackage

// ===== rtl/cli_line_assembler.sv =====
// command line assembler: edits a line from received bytes and plays it out at line end
// editing bytes are handled at once while idle; a line end with a nonempty line reads
// its up to 63 characters from the store one at a time (store read, then output
// register), issuing each next read only after the current character is taken at the
// output; an overflow error comes out in the cycle after its request; synchronous
// active-low reset clears the fill count, the sequencer and output valid; store contents
// are left as they are and are only read after being written
`timescale 1ns / 1ps

module cli_line_assembler (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_in_byte,
    output logic       o_valid,
    input  logic       i_stall,
    output logic       o_kind,
    output logic [7:0] o_line_char,
    output logic       o_last
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_LOAD = 2'd1;
    localparam logic [1:0] ST_OUT  = 2'd2;

    logic [1:0]                   r_state, n_state;
    logic [cla_pkg::COUNT_W-1:0]  r_fill, n_fill;
    logic [cla_pkg::ADDR_W-1:0]   r_idx, n_idx;
    logic                         r_out_valid, n_out_valid;
    logic                         r_out_kind, n_out_kind;
    logic [7:0]                   r_out_char, n_out_char;
    logic                         r_out_last, n_out_last;

    cla_pkg::t_wr_req wr_req;
    cla_pkg::t_rd_req rd_req;
    logic [7:0]       rd_data;

    logic in_take;
    logic out_take;
    logic is_eol;
    logic is_erase;
    logic is_print;
    logic at_last;

    cla_line_store u_store (
        .i_clk     (i_clk),
        .i_wr      (wr_req),
        .i_rd      (rd_req),
        .o_rd_data (rd_data)
    );

    assign in_take  = i_valid && (r_state == ST_IDLE);
    assign out_take = r_out_valid && !i_stall;
    assign is_eol   = (i_in_byte == cla_pkg::BYTE_CR) || (i_in_byte == cla_pkg::BYTE_LF);
    assign is_erase = (i_in_byte == cla_pkg::BYTE_BS) || (i_in_byte == cla_pkg::BYTE_DEL);
    assign is_print = (i_in_byte >= cla_pkg::PRINT_LO) && (i_in_byte <= cla_pkg::PRINT_HI);
    // compare: is the character being read the final one of the line
    assign at_last  = (r_idx == cla_pkg::ADDR_W'(r_fill - 1'b1));

    always_comb begin
        n_state     = r_state;
        n_fill      = r_fill;
        n_idx       = r_idx;
        n_out_valid = r_out_valid;
        n_out_kind  = r_out_kind;
        n_out_char  = r_out_char;
        n_out_last  = r_out_last;
        wr_req      = '0;
        rd_req      = '0;

        unique case (r_state)
            ST_IDLE: begin
                if (in_take) begin
                    priority if (is_eol) begin
                        if (r_fill != '0) begin
                            n_idx       = '0;
                            rd_req.en   = 1'b1;
                            rd_req.addr = '0;
                            n_state     = ST_LOAD;
                        end
                    end else if (is_erase) begin
                        if (r_fill != '0) begin
                            n_fill = r_fill - 1'b1;
                        end
                    end else if (is_print) begin
                        if (r_fill < cla_pkg::FULL_COUNT) begin
                            wr_req.en   = 1'b1;
                            wr_req.addr = cla_pkg::ADDR_W'(r_fill);
                            wr_req.data = i_in_byte;
                            n_fill      = r_fill + 1'b1;
                        end else begin
                            n_fill      = '0;
                            n_out_valid = 1'b1;
                            n_out_kind  = cla_pkg::KIND_ERROR;
                            n_out_char  = 8'd0;
                            n_out_last  = 1'b1;
                            n_state     = ST_OUT;
                        end
                    end else begin
                        n_state = ST_IDLE;
                    end
                end
            end
            ST_LOAD: begin
                n_out_valid = 1'b1;
                n_out_kind  = cla_pkg::KIND_CHAR;
                n_out_char  = rd_data;
                n_out_last  = at_last;
                n_state     = ST_OUT;
            end
            ST_OUT: begin
                if (out_take) begin
                    n_out_valid = 1'b0;
                    if (r_out_last) begin
                        // error result has already cleared the count
                        if (r_out_kind == cla_pkg::KIND_CHAR) begin
                            n_fill = '0;
                        end
                        n_state = ST_IDLE;
                    end else begin
                        n_idx       = r_idx + 1'b1;
                        rd_req.en   = 1'b1;
                        rd_req.addr = r_idx + 1'b1;
                        n_state     = ST_LOAD;
                    end
                end
            end
            default: begin
                n_state     = ST_IDLE;
                n_out_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_fill      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_fill      <= n_fill;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx      <= n_idx;
        r_out_kind <= n_out_kind;
        r_out_char <= n_out_char;
        r_out_last <= n_out_last;
    end

    assign o_stall     = (r_state != ST_IDLE);
    assign o_valid     = r_out_valid;
    assign o_kind      = r_out_kind;
    assign o_line_char = r_out_char;
    assign o_last      = r_out_last;

endmodule

// ===== rtl/cla_line_store.sv =====
// character store for the line being assembled, one write and one registered read port
`timescale 1ns / 1ps

module cla_line_store (
    input  logic            i_clk,
    input  cla_pkg::t_wr_req i_wr,
    input  cla_pkg::t_rd_req i_rd,
    output logic [7:0]      o_rd_data
);

    logic [7:0] r_mem [cla_pkg::STORE_DEPTH];
    logic [7:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        if (i_rd.en) begin
            r_rd_data <= r_mem[i_rd.addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== sim/testbench.sv =====
// self-checking testbench for the command line assembler
`timescale 1ns / 1ps

module testbench;

    localparam int ITEM_TARGET = 470;
    localparam int HOLD_CYCLES = 400;
    localparam int DRAIN_CYCLES = 300;
    localparam int TIMEOUT_NS = 2_000_000;

    typedef struct packed {
        logic       kind;
        logic [7:0] line_char;
        logic       last;
    } t_line_result;

    logic       i_clk;
    logic       i_rst_n = 1'b0;
    logic       i_valid = 1'b0;
    logic [7:0] i_in_byte = 8'h00;
    logic       i_stall = 1'b0;
    logic       o_stall;
    logic       o_valid;
    logic       o_kind;
    logic [7:0] o_line_char;
    logic       o_last;

    // bytes still to be typed, and the characters the block should play out
    logic [7:0]   console_bytes[$];
    t_line_result playout_q[$];

    // shadow of the line being edited
    logic [7:0]                  shadow_line[0:cla_pkg::STORE_DEPTH-1];
    logic [cla_pkg::COUNT_W-1:0] shadow_fill = '0;

    logic         hold_long = 1'b0;
    t_line_result want;
    int tx_wait = 0, tx_steady = 0, rx_wait = 0, rx_steady = 0;
    int bytes_typed = 0, total_bytes = 0, blocked_cycles = 0;
    int lines_seen = 0, chars_seen = 0, overflows_seen = 0, run_len = 0, longest_line = 0;
    int fail_cnt = 0;

    cli_line_assembler DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_in_byte   (i_in_byte),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_kind      (o_kind),
        .o_line_char (o_line_char),
        .o_last      (o_last)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("timeout with %0d results outstanding", playout_q.size());
        $display("cli_line_assembler test failed");
        $finish;
    end

    // applies one accepted byte to the shadow line and queues what it plays out
    function automatic void edit_line(input logic [7:0] b);
        if (b == cla_pkg::BYTE_CR || b == cla_pkg::BYTE_LF) begin
            for (int k = 0; k < shadow_fill; k++)
                playout_q.push_back({cla_pkg::KIND_CHAR, shadow_line[k],
                                     k == shadow_fill - 1});
            shadow_fill = '0;
        end else if (b == cla_pkg::BYTE_BS || b == cla_pkg::BYTE_DEL) begin
            if (shadow_fill != 0)
                shadow_fill = shadow_fill - 1'b1;
        end else if (b >= cla_pkg::PRINT_LO && b <= cla_pkg::PRINT_HI) begin
            if (shadow_fill < cla_pkg::FULL_COUNT) begin
                shadow_line[shadow_fill] = b;
                shadow_fill = shadow_fill + 1'b1;
            end else begin
                shadow_fill = '0;
                playout_q.push_back({cla_pkg::KIND_ERROR, 8'h00, 1'b1});
            end
        end
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 96) return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    // a byte the block must ignore: control codes other than line end and erase, or high half
    function automatic logic [7:0] noise_byte();
        logic [7:0] b;
        b = $urandom_range(0, 1) ? 8'($urandom_range(128, 255)) : 8'($urandom_range(0, 31));
        if (b == cla_pkg::BYTE_CR || b == cla_pkg::BYTE_LF || b == cla_pkg::BYTE_BS)
            b = 8'h1B;
        return b;
    endfunction

    task automatic queue_line(input int n_chars, input bit with_edits);
        for (int i = 0; i < n_chars; i++) begin
            console_bytes.push_back(8'($urandom_range(32, 126)));
            if (with_edits && $urandom_range(0, 11) == 0)
                console_bytes.push_back($urandom_range(0, 1) ? cla_pkg::BYTE_BS
                                                             : cla_pkg::BYTE_DEL);
            if (with_edits && $urandom_range(0, 19) == 0)
                console_bytes.push_back(noise_byte());
        end
        console_bytes.push_back($urandom_range(0, 1) ? cla_pkg::BYTE_CR : cla_pkg::BYTE_LF);
    endtask

    // request side
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                edit_line(i_in_byte);
                bytes_typed++;
            end
            if (i_valid && o_stall)
                blocked_cycles++;
            if (!i_valid || !o_stall) begin
                if (tx_wait > 0) begin
                    tx_wait--;
                    i_valid <= 1'b0;
                end else if (console_bytes.size() != 0) begin
                    i_valid <= 1'b1;
                    i_in_byte <= console_bytes.pop_front();
                    if (tx_steady > 0) begin
                        tx_steady--;
                        tx_wait = 0;
                    end else begin
                        tx_wait = pick_gap();
                        if ($urandom_range(0, 39) == 0)
                            tx_steady = $urandom_range(20, 60);
                    end
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // result side: check and stall
    always @(posedge i_clk) begin : result_side
        bit stall_now;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                if (playout_q.size() == 0) begin
                    $error("result with nothing expected: kind=%0d line_char=%02h last=%0d",
                           o_kind, o_line_char, o_last);
                    fail_cnt++;
                end else begin
                    want = playout_q.pop_front();
                    if (o_kind !== want.kind) begin
                        $error("kind: expected %0d, got %0d", want.kind, o_kind);
                        fail_cnt++;
                    end
                    if (o_line_char !== want.line_char) begin
                        $error("line_char: expected %02h, got %02h", want.line_char, o_line_char);
                        fail_cnt++;
                    end
                    if (o_last !== want.last) begin
                        $error("last: expected %0d, got %0d", want.last, o_last);
                        fail_cnt++;
                    end
                    if (want.kind == cla_pkg::KIND_ERROR) begin
                        overflows_seen++;
                    end else begin
                        chars_seen++;
                        run_len++;
                        if (want.last) begin
                            lines_seen++;
                            if (run_len > longest_line)
                                longest_line = run_len;
                            run_len = 0;
                        end
                    end
                end
            end
            if (rx_wait > 0) begin
                rx_wait--;
                stall_now = 1'b1;
            end else if (rx_steady > 0) begin
                rx_steady--;
                stall_now = 1'b0;
            end else begin
                stall_now = 1'b0;
                if ($urandom_range(0, 199) == 0)
                    rx_steady = $urandom_range(50, 150);
                else if ($urandom_range(0, 2) == 0)
                    rx_wait = pick_gap();
            end
            i_stall <= hold_long || stall_now;
        end
    end

    // long receiver hold-off once the directed bytes are typed, at the start of the random traffic
    initial begin
        while (bytes_typed < 150)
            @(posedge i_clk);
        hold_long <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        hold_long <= 1'b0;
    end

    initial begin : stimulus
        int r;

        // empty line ends, erase on empty line, ignored bytes
        console_bytes.push_back(cla_pkg::BYTE_LF);
        console_bytes.push_back(cla_pkg::BYTE_CR);
        console_bytes.push_back(cla_pkg::BYTE_BS);
        console_bytes.push_back(cla_pkg::BYTE_DEL);
        console_bytes.push_back(8'h00);
        console_bytes.push_back(8'hFF);
        console_bytes.push_back(8'h80);
        console_bytes.push_back(8'h1B);
        console_bytes.push_back(8'h09);
        console_bytes.push_back(8'd31);
        // printable extremes with both erase codes in between
        console_bytes.push_back(cla_pkg::PRINT_LO);
        console_bytes.push_back(cla_pkg::PRINT_HI);
        console_bytes.push_back("A");
        console_bytes.push_back(cla_pkg::BYTE_BS);
        console_bytes.push_back("z");
        console_bytes.push_back(cla_pkg::BYTE_DEL);
        console_bytes.push_back("q");
        console_bytes.push_back(cla_pkg::BYTE_CR);
        console_bytes.push_back("!");
        console_bytes.push_back(cla_pkg::BYTE_LF);
        console_bytes.push_back(cla_pkg::BYTE_DEL);

        // longest line that fits, then one character too many
        queue_line(63, 1'b0);
        queue_line(64, 1'b0);

        while (console_bytes.size() < ITEM_TARGET) begin
            r = $urandom_range(0, 99);
            if (r < 70) begin
                queue_line($urandom_range(1, 12), 1'b1);
            end else if (r < 88) begin
                queue_line($urandom_range(13, 40), 1'b1);
            end else if (r < 92) begin
                queue_line($urandom_range(58, 70), 1'b0);
            end else if (r < 97) begin
                // unfinished fragment of noise, erase and text
                repeat ($urandom_range(1, 8)) begin
                    case ($urandom_range(0, 2))
                        0: console_bytes.push_back(noise_byte());
                        1: console_bytes.push_back($urandom_range(0, 1) ? cla_pkg::BYTE_BS
                                                                        : cla_pkg::BYTE_DEL);
                        default: console_bytes.push_back(8'($urandom_range(32, 126)));
                    endcase
                end
            end else begin
                console_bytes.push_back($urandom_range(0, 1) ? cla_pkg::BYTE_CR
                                                             : cla_pkg::BYTE_LF);
            end
        end
        console_bytes.push_back(cla_pkg::BYTE_LF);
        total_bytes = console_bytes.size();

        while (bytes_typed < total_bytes)
            @(posedge i_clk);
        while (playout_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("typed %0d bytes; %0d lines played out (%0d chars, longest %0d), %0d overflows",
                 bytes_typed, lines_seen, chars_seen, longest_line, overflows_seen);
        $display("input held back on %0d cycles, %0d check failures", blocked_cycles, fail_cnt);
        if (fail_cnt == 0 && playout_q.size() == 0)
            $display("cli_line_assembler test passed");
        else
            $display("cli_line_assembler test failed");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/cla_pkg.sv
rtl/cla_line_store.sv
rtl/cli_line_assembler.sv
sim/testbench.sv
